### hw/rtl/threefish256_block_encrypt_defines.svh
// Assertion macros shared by the encryption pipeline.
`ifndef THREEFISH256_BLOCK_ENCRYPT_DEFINES_SVH
`define THREEFISH256_BLOCK_ENCRYPT_DEFINES_SVH

// Checks that a condition implies a consequence in the same cycle.
`define TF256_ASSERT_SAME(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("tf256 check failed");

// Checks that a condition implies a consequence in the next cycle.
`define TF256_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("tf256 check failed");

`endif

### hw/rtl/tf256_pkg.sv
package tf256_pkg;

  localparam int WORD_W = 64;

  localparam logic [WORD_W-1:0] KEY_PARITY = 64'h1BD11BDAA9FC1A22;
  localparam logic [WORD_W-1:0] ROT_A = 64'h203a2e190517340e;
  localparam logic [WORD_W-1:0] ROT_B = 64'h20160c2125283910;

  typedef logic [WORD_W-1:0] word_t;

  typedef struct packed {
    word_t [3:0] w;
    word_t [4:0] k;
    word_t [2:0] t;
  } tf_state_t;

endpackage

### hw/rtl/tf256_expand.sv
module tf256_expand (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 valid_in,
  input  tf256_pkg::word_t     plain_word_0,
  input  tf256_pkg::word_t     plain_word_1,
  input  tf256_pkg::word_t     plain_word_2,
  input  tf256_pkg::word_t     plain_word_3,
  input  tf256_pkg::word_t     key_word_0,
  input  tf256_pkg::word_t     key_word_1,
  input  tf256_pkg::word_t     key_word_2,
  input  tf256_pkg::word_t     key_word_3,
  input  tf256_pkg::word_t     tweak_word_0,
  input  tf256_pkg::word_t     tweak_word_1,
  output logic                 valid_out,
  output tf256_pkg::tf_state_t state_out
);

  tf256_pkg::tf_state_t state_next;

  always_comb begin
    state_next.w[0] = plain_word_0;
    state_next.w[1] = plain_word_1;
    state_next.w[2] = plain_word_2;
    state_next.w[3] = plain_word_3;
    state_next.k[0] = key_word_0;
    state_next.k[1] = key_word_1;
    state_next.k[2] = key_word_2;
    state_next.k[3] = key_word_3;
    state_next.k[4] = tf256_pkg::KEY_PARITY ^ key_word_0 ^ key_word_1 ^ key_word_2
                      ^ key_word_3;
    state_next.t[0] = tweak_word_0;
    state_next.t[1] = tweak_word_1;
    state_next.t[2] = tweak_word_0 ^ tweak_word_1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out <= state_next;
    end
  end

endmodule

### hw/rtl/tf256_subkey.sv
module tf256_subkey #(
  parameter int SUBKEY_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 valid_in,
  input  tf256_pkg::tf_state_t state_in,
  output logic                 valid_out,
  output tf256_pkg::tf_state_t state_out
);

  localparam int K0 = SUBKEY_INDEX % 5;
  localparam int K1 = (SUBKEY_INDEX + 1) % 5;
  localparam int K2 = (SUBKEY_INDEX + 2) % 5;
  localparam int K3 = (SUBKEY_INDEX + 3) % 5;
  localparam int T0 = SUBKEY_INDEX % 3;
  localparam int T1 = (SUBKEY_INDEX + 1) % 3;
  localparam tf256_pkg::word_t S_WORD = tf256_pkg::WORD_W'(SUBKEY_INDEX);

  tf256_pkg::tf_state_t state_next;

  always_comb begin
    state_next      = state_in;
    state_next.w[0] = state_in.w[0] + state_in.k[K0];
    state_next.w[1] = state_in.w[1] + state_in.k[K1] + state_in.t[T0];
    state_next.w[2] = state_in.w[2] + state_in.k[K2] + state_in.t[T1];
    state_next.w[3] = state_in.w[3] + state_in.k[K3] + S_WORD;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out <= state_next;
    end
  end

endmodule

### hw/rtl/tf256_round.sv
module tf256_round #(
  parameter int ROUND_INDEX = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic                 valid_in,
  input  tf256_pkg::tf_state_t state_in,
  output logic                 valid_out,
  output tf256_pkg::tf_state_t state_out
);

  localparam int RA = int'(tf256_pkg::ROT_A[8*(ROUND_INDEX%8) +: 8]);
  localparam int RB = int'(tf256_pkg::ROT_B[8*(ROUND_INDEX%8) +: 8]);
  localparam int WW = tf256_pkg::WORD_W;

  tf256_pkg::tf_state_t state_next;
  tf256_pkg::word_t     sum_a;
  tf256_pkg::word_t     sum_b;
  tf256_pkg::word_t     mix_a;
  tf256_pkg::word_t     mix_b;

  always_comb begin
    sum_a = state_in.w[0] + state_in.w[1];
    sum_b = state_in.w[2] + state_in.w[3];
    mix_a = ((state_in.w[1] << RA) | (state_in.w[1] >> (WW - RA))) ^ sum_a;
    mix_b = ((state_in.w[3] << RB) | (state_in.w[3] >> (WW - RB))) ^ sum_b;
    state_next      = state_in;
    state_next.w[0] = sum_a;
    state_next.w[1] = mix_b;
    state_next.w[2] = sum_b;
    state_next.w[3] = mix_a;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (advance) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      state_out <= state_next;
    end
  end

endmodule

### hw/rtl/threefish256_block_encrypt.sv
// Channel  Handshake                Words
// input    in_valid / in_stall      plain_word_0..3, key_word_0..3, tweak_word_0..1
// output   out_valid / out_stall    cipher_word_0..3
//
// One block enters per cycle while in_stall is low. The final subkey stage exists
// only when ROUND_COUNT is a multiple of four.
// Each round and each subkey injection owns one register stage; the key extension
// owns the first. A stall while out_valid is high freezes every stage at once.
// Synchronous reset clears all stage valid bits.
`include "threefish256_block_encrypt_defines.svh"

module threefish256_block_encrypt #(
  parameter int ROUND_COUNT = 72
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  tf256_pkg::word_t plain_word_0,
  input  tf256_pkg::word_t plain_word_1,
  input  tf256_pkg::word_t plain_word_2,
  input  tf256_pkg::word_t plain_word_3,
  input  tf256_pkg::word_t key_word_0,
  input  tf256_pkg::word_t key_word_1,
  input  tf256_pkg::word_t key_word_2,
  input  tf256_pkg::word_t key_word_3,
  input  tf256_pkg::word_t tweak_word_0,
  input  tf256_pkg::word_t tweak_word_1,
  output logic             out_valid,
  input  logic             out_stall,
  output tf256_pkg::word_t cipher_word_0,
  output tf256_pkg::word_t cipher_word_1,
  output tf256_pkg::word_t cipher_word_2,
  output tf256_pkg::word_t cipher_word_3
);

  localparam int LAST = (ROUND_COUNT % 4 == 0) ? (ROUND_COUNT + ROUND_COUNT / 4 + 1)
                                               : (ROUND_COUNT + (ROUND_COUNT - 1) / 4 + 1);

  logic                 advance;
  logic [LAST:0]        v;
  tf256_pkg::tf_state_t st [LAST+1];

  assign advance  = !(out_valid && out_stall);
  assign in_stall = !advance;

  tf256_expand u_expand (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .valid_in     (in_valid),
    .plain_word_0 (plain_word_0),
    .plain_word_1 (plain_word_1),
    .plain_word_2 (plain_word_2),
    .plain_word_3 (plain_word_3),
    .key_word_0   (key_word_0),
    .key_word_1   (key_word_1),
    .key_word_2   (key_word_2),
    .key_word_3   (key_word_3),
    .tweak_word_0 (tweak_word_0),
    .tweak_word_1 (tweak_word_1),
    .valid_out    (v[0]),
    .state_out    (st[0])
  );

  for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
    if (r % 4 == 0) begin : g_inject
      tf256_subkey #(.SUBKEY_INDEX(r / 4)) u_subkey (
        .clk       (clk),
        .rst       (rst),
        .advance   (advance),
        .valid_in  (v[5*(r/4)]),
        .state_in  (st[5*(r/4)]),
        .valid_out (v[5*(r/4)+1]),
        .state_out (st[5*(r/4)+1])
      );
    end
    tf256_round #(.ROUND_INDEX(r)) u_round (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (v[r+r/4+1]),
      .state_in  (st[r+r/4+1]),
      .valid_out (v[r+r/4+2]),
      .state_out (st[r+r/4+2])
    );
  end

  if (ROUND_COUNT % 4 == 0) begin : g_final
    tf256_subkey #(.SUBKEY_INDEX(ROUND_COUNT / 4)) u_subkey (
      .clk       (clk),
      .rst       (rst),
      .advance   (advance),
      .valid_in  (v[LAST-1]),
      .state_in  (st[LAST-1]),
      .valid_out (v[LAST]),
      .state_out (st[LAST])
    );
  end

  assign out_valid     = v[LAST];
  assign cipher_word_0 = st[LAST].w[0];
  assign cipher_word_1 = st[LAST].w[1];
  assign cipher_word_2 = st[LAST].w[2];
  assign cipher_word_3 = st[LAST].w[3];

  `TF256_ASSERT_NEXT(a_stall_freezes, !advance, $stable(v))
  `TF256_ASSERT_NEXT(a_valid_shift, advance, v[LAST:1] == $past(v[LAST-1:0]))
  `TF256_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, v[0])

endmodule

### bench/tb_threefish256_block_encrypt.sv
`timescale 1ns / 1ps

typedef struct packed {
  tf256_pkg::word_t [3:0] plain;
  tf256_pkg::word_t [3:0] key;
  tf256_pkg::word_t [1:0] tweak;
} cipher_job_t;

typedef tf256_pkg::word_t [3:0] cipher_blk_t;

class cipher_scoreboard;
  int unsigned rounds;
  int unsigned errors;
  int unsigned shown;
  cipher_blk_t expected_q[$];

  function new(int unsigned n);
    rounds = n;
    errors = 0;
    shown = 0;
  endfunction

  function tf256_pkg::word_t rotl(tf256_pkg::word_t v, int unsigned n);
    n = n % 64;
    if (n == 0) return v;
    return (v << n) | (v >> (64 - n));
  endfunction

  function cipher_blk_t encrypt(cipher_job_t j);
    tf256_pkg::word_t [3:0] w;
    tf256_pkg::word_t [4:0] k;
    tf256_pkg::word_t [2:0] t;
    tf256_pkg::word_t sw;
    int unsigned s;
    w = j.plain;
    k[3:0] = j.key;
    k[4] = tf256_pkg::KEY_PARITY ^ j.key[0] ^ j.key[1] ^ j.key[2] ^ j.key[3];
    t[1:0] = j.tweak;
    t[2] = j.tweak[0] ^ j.tweak[1];
    for (int r = 0; r <= rounds; r++) begin
      if (r % 4 == 0) begin
        s = r / 4;
        w[0] = w[0] + k[s % 5];
        w[1] = w[1] + k[(s + 1) % 5] + t[s % 3];
        w[2] = w[2] + k[(s + 2) % 5] + t[(s + 1) % 3];
        w[3] = w[3] + k[(s + 3) % 5] + tf256_pkg::word_t'(s);
      end
      if (r == rounds) break;
      w[0] = w[0] + w[1];
      w[1] = rotl(w[1], tf256_pkg::ROT_A[8 * (r % 8) +: 8]) ^ w[0];
      w[2] = w[2] + w[3];
      w[3] = rotl(w[3], tf256_pkg::ROT_B[8 * (r % 8) +: 8]) ^ w[2];
      sw = w[1];
      w[1] = w[3];
      w[3] = sw;
    end
    return w;
  endfunction

  function void note_block(cipher_job_t j);
    expected_q.push_back(encrypt(j));
  endfunction

  function void check_block(cipher_blk_t got);
    cipher_blk_t want;
    if (expected_q.size() == 0) begin
      errors++;
      if (shown++ < 200)
        $display("%0t: output word with nothing expected, actual %h", $time, got);
      return;
    end
    want = expected_q.pop_front();
    for (int i = 0; i < 4; i++) begin
      if (want[i] !== got[i]) begin
        errors++;
        if (shown++ < 200)
          $display("%0t: cipher_word_%0d expected %h actual %h", $time, i, want[i], got[i]);
      end
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_threefish256_block_encrypt;

  localparam int ROUNDS = 72;
  localparam int LATENCY = ROUNDS + ROUNDS / 4 + 2;
  localparam int RANDOM_ITEMS = 1630;
  localparam int QUIET_ITEMS = 200;
  localparam int LIMIT_CYCLES = 600_000;

  logic clk;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic out_valid;
  logic out_stall = 1'b0;
  tf256_pkg::word_t plain_word_0 = '0;
  tf256_pkg::word_t plain_word_1 = '0;
  tf256_pkg::word_t plain_word_2 = '0;
  tf256_pkg::word_t plain_word_3 = '0;
  tf256_pkg::word_t key_word_0 = '0;
  tf256_pkg::word_t key_word_1 = '0;
  tf256_pkg::word_t key_word_2 = '0;
  tf256_pkg::word_t key_word_3 = '0;
  tf256_pkg::word_t tweak_word_0 = '0;
  tf256_pkg::word_t tweak_word_1 = '0;
  tf256_pkg::word_t cipher_word_0;
  tf256_pkg::word_t cipher_word_1;
  tf256_pkg::word_t cipher_word_2;
  tf256_pkg::word_t cipher_word_3;
  bit quiet = 1'b0;

  cipher_scoreboard cipher_sb = new(ROUNDS);

  threefish256_block_encrypt #(.ROUND_COUNT(ROUNDS)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .plain_word_0 (plain_word_0),
    .plain_word_1 (plain_word_1),
    .plain_word_2 (plain_word_2),
    .plain_word_3 (plain_word_3),
    .key_word_0   (key_word_0),
    .key_word_1   (key_word_1),
    .key_word_2   (key_word_2),
    .key_word_3   (key_word_3),
    .tweak_word_0 (tweak_word_0),
    .tweak_word_1 (tweak_word_1),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cipher_word_0(cipher_word_0),
    .cipher_word_1(cipher_word_1),
    .cipher_word_2(cipher_word_2),
    .cipher_word_3(cipher_word_3)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("tb_threefish256_block_encrypt: FAIL");
    $finish;
  end

  function automatic tf256_pkg::word_t rand_word();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return '1;
      2: return tf256_pkg::word_t'(1) << $urandom_range(0, 63);
      3: return ~(tf256_pkg::word_t'(1) << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic cipher_job_t random_job();
    cipher_job_t j;
    for (int i = 0; i < 4; i++) begin
      j.plain[i] = rand_word();
      j.key[i] = rand_word();
    end
    for (int i = 0; i < 2; i++) j.tweak[i] = rand_word();
    return j;
  endfunction

  task automatic send_block(input cipher_job_t j);
    bit taken;
    in_valid <= 1'b1;
    plain_word_0 <= j.plain[0];
    plain_word_1 <= j.plain[1];
    plain_word_2 <= j.plain[2];
    plain_word_3 <= j.plain[3];
    key_word_0 <= j.key[0];
    key_word_1 <= j.key[1];
    key_word_2 <= j.key[2];
    key_word_3 <= j.key[3];
    tweak_word_0 <= j.tweak[0];
    tweak_word_1 <= j.tweak[1];
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    cipher_sb.note_block(j);
  endtask

  task automatic idle_sender(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (cipher_sb.pending() != 0);
  endtask

  initial begin
    int n;
    forever begin
      if (rst || quiet) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 25);
        out_stall <= 1'b0;
        repeat (n) @(posedge clk);
        if (!quiet) begin
          out_stall <= 1'b1;
          repeat ($urandom_range(1, 18)) begin
            if (!quiet) @(posedge clk);
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall)
      cipher_sb.check_block({cipher_word_3, cipher_word_2, cipher_word_1, cipher_word_0});
  end

  initial begin
    cipher_job_t job;
    int idle_pct;
    idle_pct = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int d = 0; d < 20; d++) begin
      job = '0;
      case (d)
        1: job = '1;
        2: job.plain = '1;
        3: job.key = '1;
        4: job.tweak = '1;
        5: job.tweak[0] = '1;
        6: begin
          // Key words that cancel the parity constant leave the fifth key word at zero.
          job.key[0] = tf256_pkg::KEY_PARITY;
          job.plain = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom};
        end
        7: begin
          // Equal tweak words make the third tweak word zero.
          job.tweak[0] = {$urandom, $urandom};
          job.tweak[1] = job.tweak[0];
        end
        8: job = {20{32'h5555_5555}};
        9: job = {20{32'haaaa_aaaa}};
        10: job = {10{64'h8000_0000_0000_0000}};
        11: job = {10{64'h1}};
        12: begin
          job.plain = '1;
          job.key = {tf256_pkg::word_t'(0), tf256_pkg::word_t'(0), tf256_pkg::word_t'(0),
                     tf256_pkg::word_t'(1)};
        end
        13: begin
          job.plain = {tf256_pkg::word_t'(3), tf256_pkg::word_t'(2), tf256_pkg::word_t'(1),
                       tf256_pkg::word_t'(0)};
          job.key = {tf256_pkg::word_t'(7), tf256_pkg::word_t'(6), tf256_pkg::word_t'(5),
                     tf256_pkg::word_t'(4)};
          job.tweak = {tf256_pkg::word_t'(9), tf256_pkg::word_t'(8)};
        end
        14: job.tweak[1] = '1;
        15: job.key[3] = 64'h8000_0000_0000_0000;
        0: job = '0;
        default: job = random_job();
      endcase
      send_block(job);
      if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 18));
    end
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 100 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 15;
          default: idle_pct = 50;
        endcase
      end
      if (i == RANDOM_ITEMS / 2) wait_drained();
      if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
      job = random_job();
      send_block(job);
      if (!quiet && $urandom_range(0, 99) < idle_pct) idle_sender($urandom_range(1, 18));
    end

    in_valid <= 1'b0;
    while (cipher_sb.pending() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (cipher_sb.errors == 0) begin
      $display("tb_threefish256_block_encrypt: PASS");
    end else begin
      $display("tb_threefish256_block_encrypt: FAIL");
    end
    $finish;
  end
endmodule
